/* rtl/core/srp_pkg.sv */
// shared types and constants of the stream pattern replace block
// no dependencies
package srp_pkg;

    localparam int PATTERN_MAX     = 8;
    localparam int REPLACEMENT_MAX = 8;
    localparam int MAX_RESULTS     = (PATTERN_MAX > REPLACEMENT_MAX) ? PATTERN_MAX
                                                                    : REPLACEMENT_MAX;
    localparam int CFG_W     = 64;
    localparam int LEN_W     = 4;
    localparam int IDX_W     = 2;
    localparam int CNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int WIN_CNT_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    typedef logic [7:0] byte_t;

    typedef enum logic [IDX_W-1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] pattern_bytes;
        logic [LEN_W-1:0] pattern_length;
        logic [CFG_W-1:0] replacement_bytes;
        logic [LEN_W-1:0] replacement_length;
    } cfg_t;

    // results of one item, first result in entry 0
    typedef struct packed {
        byte_t [MAX_RESULTS-1:0] bytes;
        logic  [CNT_W-1:0]       count;
        logic                    last;
        logic                    empty;
    } burst_t;

endpackage

/* rtl/core/srp_in_if.sv */
// input channel of the stream pattern replace block: one text byte per item
// depends on srp_pkg
interface srp_in_if;
    import srp_pkg::*;

    logic  valid;
    logic  ready;
    byte_t in_byte;
    logic  in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
    modport mon    (input valid, input in_byte, input in_last, input ready);
endinterface

/* rtl/core/srp_out_if.sv */
// output channel of the stream pattern replace block: one result byte per item
// depends on srp_pkg
interface srp_out_if;
    import srp_pkg::*;

    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  out_valid;
    logic  out_last;

    modport source (output valid, output out_byte, output out_valid, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input out_valid, input out_last,
                    output ready);
    modport mon    (input valid, input out_byte, input out_valid, input out_last,
                    input ready);
endinterface

/* rtl/core/srp_step.sv */
// per-item match logic: appends a byte to the window, finds the match state,
// builds the results of the item and the next window; depends on srp_pkg
module srp_step
    import srp_pkg::*;
(
    input  cfg_t                        cfg,
    input  byte_t [PATTERN_MAX-1:0]     win_bytes,
    input  logic  [WIN_CNT_W-1:0]       win_count,
    input  byte_t                       in_byte,
    input  logic                        in_last,
    output burst_t                      burst,
    output byte_t [PATTERN_MAX-1:0]     win_bytes_next,
    output logic  [WIN_CNT_W-1:0]       win_count_next
);

    logic  [LEN_W-1:0]           pat_len;
    logic  [LEN_W-1:0]           rep_len;
    logic  [LEN_W-1:0]           len_l;
    logic  [LEN_W-1:0]           k_sel;
    byte_t [PATTERN_MAX-1:0]     pat;
    byte_t [PATTERN_MAX-1:0]     seq;
    logic  [PATTERN_MAX-1:0]     match_at;
    logic                        full;

    // saturated lengths and pattern lanes
    always_comb
    begin
        pat_len = (cfg.pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                              : cfg.pattern_length;
        rep_len = (cfg.replacement_length > LEN_W'(REPLACEMENT_MAX))
                  ? LEN_W'(REPLACEMENT_MAX) : cfg.replacement_length;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pat[i] = cfg.pattern_bytes[i*8 +: 8];
        end
    end

    // window with the new byte appended
    always_comb
    begin
        len_l = LEN_W'(win_count) + LEN_W'(1);
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (LEN_W'(i) < LEN_W'(win_count))
            begin
                seq[i] = win_bytes[i];
            end
            else
            begin
                seq[i] = in_byte;
            end
        end
    end

    // match_at[k]: the tail from position k is a prefix of the pattern
    always_comb
    begin
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            match_at[k] = 1'b1;
            for (int j = 0; j < PATTERN_MAX; j++)
            begin
                if (k + j < PATTERN_MAX)
                begin
                    if ((LEN_W'(k + j) < len_l) && (seq[k + j] != pat[j]))
                    begin
                        match_at[k] = 1'b0;
                    end
                end
            end
        end
        // first surviving tail; the empty tail always survives
        k_sel = len_l;
        for (int k = PATTERN_MAX - 1; k >= 0; k--)
        begin
            if ((LEN_W'(k) < len_l) && match_at[k])
            begin
                k_sel = LEN_W'(k);
            end
        end
        full = match_at[0] && (len_l == pat_len);
    end

    always_comb
    begin
        burst.last     = in_last;
        burst.empty    = 1'b0;
        burst.count    = '0;
        win_count_next = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (i < PATTERN_MAX)
            begin
                burst.bytes[i] = seq[i];
            end
            else
            begin
                burst.bytes[i] = '0;
            end
        end
        win_bytes_next = seq;

        if (pat_len == '0)
        begin
            burst.bytes[0] = in_byte;
            burst.count    = CNT_W'(1);
        end
        else if (full)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                if (i < REPLACEMENT_MAX && i < CFG_W / 8)
                begin
                    burst.bytes[i] = cfg.replacement_bytes[i*8 +: 8];
                end
            end
            burst.count = CNT_W'(rep_len);
        end
        else if (in_last)
        begin
            // flush the whole window
            burst.count = CNT_W'(len_l);
        end
        else
        begin
            burst.count    = CNT_W'(k_sel);
            win_count_next = WIN_CNT_W'(len_l - k_sel);
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                for (int k = 0; k < PATTERN_MAX; k++)
                begin
                    if ((LEN_W'(k) == k_sel) && (i + k < PATTERN_MAX))
                    begin
                        win_bytes_next[i] = seq[i + k];
                    end
                end
            end
        end

        // end of text with nothing to give: empty marker
        if (in_last && (burst.count == '0))
        begin
            burst.count    = CNT_W'(1);
            burst.empty    = 1'b1;
            burst.bytes[0] = '0;
        end
    end

endmodule

/* rtl/core/srp_burst.sv */
// result register: holds the results of one item and hands them out one per cycle while the output is ready
// depends on srp_pkg and srp_out_if
module srp_burst
    import srp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  burst_t           load_burst,
    output logic             can_load,
    srp_out_if.source        out_ch
);

    burst_t burst_reg;
    burst_t burst_next;
    logic   pop;

    assign pop      = out_ch.valid && out_ch.ready;
    assign can_load = (burst_reg.count == '0) || ((burst_reg.count == CNT_W'(1)) && pop);

    always_comb
    begin
        burst_next = burst_reg;
        if (pop)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                burst_next.bytes[i] = burst_reg.bytes[i + 1];
            end
            burst_next.count = burst_reg.count - CNT_W'(1);
        end
        if (load)
        begin
            burst_next = load_burst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_reg <= '0;
        end
        else
        begin
            burst_reg <= burst_next;
        end
    end

    assign out_ch.valid     = (burst_reg.count != '0);
    assign out_ch.out_byte  = burst_reg.bytes[0];
    assign out_ch.out_valid = !burst_reg.empty;
    assign out_ch.out_last  = burst_reg.last && (burst_reg.count == CNT_W'(1));

endmodule

/* rtl/core/stream_pattern_replace.sv */
// stream pattern replace: an input item passes the input register, then the result register,
// on its way to its first result item; throughput one input item per cycle while each item
// gives at most one result and the output is ready; an item that gives n > 1 results
// stalls the input while the result register hands them out
// reset: window empty and all configuration registers zero at once, no clearing pass
// depends on srp_pkg, srp_in_if, srp_out_if, srp_step, srp_burst
module stream_pattern_replace
    import srp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    srp_in_if.sink            in_ch,
    srp_out_if.source         out_ch
);

    // configuration registers
    cfg_t                     cfg_reg;

    // input register: one item waiting for the match logic
    logic                     s1_valid_reg;
    byte_t                    s1_byte_reg;
    logic                     s1_last_reg;

    // pending window, always a proper prefix of the pattern
    byte_t [PATTERN_MAX-1:0]  win_bytes_reg;
    byte_t [PATTERN_MAX-1:0]  win_bytes_next;
    logic  [WIN_CNT_W-1:0]    win_count_reg;
    logic  [WIN_CNT_W-1:0]    win_count_next;

    burst_t                   step_burst;
    logic                     can_load;
    logic                     advance;

    // the held item moves on once the result register is free or frees up now
    assign advance     = s1_valid_reg && can_load;
    assign in_ch.ready = !s1_valid_reg || advance;

    // configuration writes; any write empties the window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_BYTES:      cfg_reg.pattern_bytes      <= cfg_data;
                REG_PATTERN_LENGTH:     cfg_reg.pattern_length     <= cfg_data[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  cfg_reg.replacement_bytes  <= cfg_data;
                REG_REPLACEMENT_LENGTH: cfg_reg.replacement_length <= cfg_data[LEN_W-1:0];
                default:                cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_byte_reg <= in_ch.in_byte;
            s1_last_reg <= in_ch.in_last;
        end
    end

    // window count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            win_count_reg <= '0;
        end
        else if (advance)
        begin
            win_count_reg <= win_count_next;
        end
    end

    // window bytes; entries past the count are never read
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            win_bytes_reg <= win_bytes_next;
        end
    end

    // match, replace and flush for the held item
    srp_step u_step (
        .cfg            (cfg_reg),
        .win_bytes      (win_bytes_reg),
        .win_count      (win_count_reg),
        .in_byte        (s1_byte_reg),
        .in_last        (s1_last_reg),
        .burst          (step_burst),
        .win_bytes_next (win_bytes_next),
        .win_count_next (win_count_next)
    );

    // result register, drained one item per cycle while the output is ready
    srp_burst u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .load_burst (step_burst),
        .can_load   (can_load),
        .out_ch     (out_ch)
    );

endmodule

/* rtl/core/srp_checker.sv */
// port-level checks for the stream pattern replace block, bound to the top level
// depends on srp_pkg
module srp_checker
    import srp_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_ready,
    input byte_t  in_byte,
    input logic   in_last,
    input logic   res_valid,
    input logic   res_ready,
    input byte_t  out_byte,
    input logic   out_valid,
    input logic   out_last
);

    // an empty marker only ever closes a text
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !out_valid) |-> out_last)
        else $error("empty marker without last");

    // an empty marker carries a zero byte
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !out_valid) |-> (out_byte == '0))
        else $error("empty marker with non-zero byte");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=>
        (res_valid && $stable(out_byte) && $stable(out_valid) && $stable(out_last)))
        else $error("stalled result changed");

    // a stalled input item holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |=>
        (in_valid && $stable(in_byte) && $stable(in_last)))
        else $error("stalled input item changed");

endmodule

bind stream_pattern_replace srp_checker u_srp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_byte   (in_ch.in_byte),
    .in_last   (in_ch.in_last),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_valid (out_ch.out_valid),
    .out_last  (out_ch.out_last)
);
